// ----- design/pse_pkg.sv -----
package pse_pkg;

    localparam int DIM_W = 13;
    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_ONES = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD = 17'd65521;
    localparam logic [15:0] BLOCK_MAX = 16'hffff;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        JOB_START,
        JOB_PIXEL,
        JOB_ERROR
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [23:0]      pixel;
        logic             row_start;
        logic             finish;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } job_t;

    // handshake between the front and the job queue
    typedef struct packed {
        logic push;
        job_t job;
    } job_push_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_START,
        BK_RAW,
        BK_FIN,
        BK_ERR
    } back_state_t;

    // one byte through the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- design/png_stored_encoder.sv -----
// An accepted item passes through the job queue and the back-end sequencer, and its bytes
// leave through the byte-wide output register, one per cycle while m_tready allows; a pixel
// yields 3 or 4 bytes (5 more at a block boundary, 20 more to close), a start item 43.
// A four-entry job queue lets input items be taken while earlier bytes still drain.
// Reset: synchronous, active low; clears the queue, sequencer and checksums, no image
// open, and both dimension registers return to 1.
module png_stored_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] pixel_color
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] data_byte
    output logic        m_tlast,   // last_of_run
    output logic [1:0]  m_tuser    // [0] image_done, [1] error
);

    pse_pkg::job_push_t push;
    pse_pkg::job_t      job;
    logic queue_full, job_valid, pop;

    pse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .pixel      (s_tdata),
        .command    (s_tuser),
        .queue_full (queue_full),
        .push_out   (push)
    );

    pse_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_in   (push),
        .full      (queue_full),
        .pop       (pop),
        .job_valid (job_valid),
        .job_out   (job)
    );

    pse_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job_in      (job),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .data_byte   (m_tdata),
        .last_of_run (m_tlast),
        .image_done  (m_tuser[0]),
        .error       (m_tuser[1])
    );

    // an error item is a lone zero byte
    a_err_item: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tlast && (m_tdata == 8'h00) && !m_tuser[0])
        else $error("error item malformed");

    // the end of the file also ends the item
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("image_done without last");

    // a pop only happens with a job waiting
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> job_valid)
        else $error("pop from empty queue");

endmodule

// ----- design/pse_front.sv -----
module pse_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [12:0]             cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             pixel,
    input  logic                    command,
    input  logic                    queue_full,
    output pse_pkg::job_push_t      push_out
);

    logic [12:0] cfg_w_reg, cfg_h_reg;
    logic [12:0] cur_w_reg, cur_w_next;
    logic [12:0] cur_h_reg, cur_h_next;
    logic [12:0] col_reg, col_next;
    logic [12:0] row_reg, row_next;
    logic        open_reg, open_next;
    logic [12:0] w_clamp, h_clamp, col_inc, row_inc;
    logic        accept, wrap, last_pixel;

    function automatic logic [12:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0) return 13'd1;
        if (v > pse_pkg::MAX_DIM) return pse_pkg::MAX_DIM;
        return v;
    endfunction

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign w_clamp  = clamp_dim(cfg_w_reg);
    assign h_clamp  = clamp_dim(cfg_h_reg);
    assign col_inc  = col_reg + 13'd1;
    assign row_inc  = row_reg + 13'd1;
    assign wrap     = col_inc >= cur_w_reg;
    assign last_pixel = wrap && (row_inc >= cur_h_reg);

    // hold the dimension registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_w_reg <= 13'd1;
            cfg_h_reg <= 13'd1;
        end else if (cfg_we) begin
            if (cfg_index) cfg_h_reg <= cfg_wdata;
            else cfg_w_reg <= cfg_wdata;
        end
    end

    // classify the item and track the image position
    always_comb begin
        cur_w_next = cur_w_reg;
        cur_h_next = cur_h_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        open_next  = open_reg;
        push_out.push          = accept;
        push_out.job.kind      = pse_pkg::JOB_ERROR;
        push_out.job.pixel     = pixel;
        push_out.job.row_start = (col_reg == 13'd0);
        push_out.job.finish    = last_pixel;
        push_out.job.width     = w_clamp;
        push_out.job.height    = h_clamp;
        if (accept) begin
            if (!command) begin
                push_out.job.kind = pse_pkg::JOB_START;
                cur_w_next = w_clamp;
                cur_h_next = h_clamp;
                col_next   = 13'd0;
                row_next   = 13'd0;
                open_next  = 1'b1;
            end else if (open_reg) begin
                push_out.job.kind = pse_pkg::JOB_PIXEL;
                if (wrap) begin
                    col_next = 13'd0;
                    row_next = row_inc;
                    if (last_pixel) open_next = 1'b0;
                end else begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_w_reg <= 13'd1;
            cur_h_reg <= 13'd1;
            col_reg   <= 13'd0;
            row_reg   <= 13'd0;
            open_reg  <= 1'b0;
        end else begin
            cur_w_reg <= cur_w_next;
            cur_h_reg <= cur_h_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ----- design/pse_fifo.sv -----
module pse_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  pse_pkg::job_push_t    push_in,
    output logic                  full,
    input  logic                  pop,
    output logic                  job_valid,
    output pse_pkg::job_t         job_out
);

    pse_pkg::job_t mem [pse_pkg::FIFO_DEPTH];
    logic [pse_pkg::FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [pse_pkg::FIFO_AW:0]   count_reg;
    logic do_push, do_pop;

    assign full      = (count_reg == (pse_pkg::FIFO_AW+1)'(pse_pkg::FIFO_DEPTH));
    assign job_valid = (count_reg != '0);
    assign job_out   = mem[rd_ptr_reg];
    assign do_push   = push_in.push && !full;
    assign do_pop    = pop && job_valid;

    // store the item
    always_ff @(posedge aclk) begin
        if (do_push) mem[wr_ptr_reg] <= push_in.job;
    end

    // advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop) count_reg <= count_reg + 1'b1;
            else if (!do_push && do_pop) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ----- design/pse_back.sv -----
module pse_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           job_valid,
    input  pse_pkg::job_t  job_in,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     data_byte,
    output logic           last_of_run,
    output logic           image_done,
    output logic           error
);

    pse_pkg::back_state_t state_reg, state_next;
    pse_pkg::job_t job_reg;
    logic [5:0]  step_reg, step_next;
    logic [1:0]  slot_reg, slot_next;
    logic [2:0]  hdr_reg, hdr_next;
    logic [31:0] crc_reg;
    logic [15:0] alo_reg, ahi_reg;
    logic [25:0] raw_reg;
    logic [10:0] blocks_reg;
    logic [26:0] idat_reg;
    logic [25:0] raw_left_reg;
    logic [15:0] block_left_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg, out_done_reg, out_err_reg;

    logic [7:0]  byte_val;
    logic        emit, load, feed, crc_rst, is_last, done_flag, err_flag;
    logic        in_header, raw_data;
    logic [31:0] crc_in, crc_inv, idat_word, adler_word, w_word, h_word;
    logic [15:0] blk_n;
    logic [13:0] row_bytes;
    logic [26:0] product, ceil_x;
    logic [10:0] q0;
    logic [16:0] rem, lo_sum, hi_sum;
    logic [15:0] lo_new, hi_new;

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] i);
        return w[8*(3-i) +: 8];
    endfunction

    assign crc_inv    = crc_reg ^ pse_pkg::CRC_ONES;
    assign idat_word  = {5'b0, idat_reg};
    assign adler_word = {ahi_reg, alo_reg};
    assign w_word     = {19'b0, job_reg.width};
    assign h_word     = {19'b0, job_reg.height};
    assign in_header  = (block_left_reg == 16'd0);
    assign blk_n      = (raw_left_reg[25:16] == 10'd0) ? raw_left_reg[15:0] : pse_pkg::BLOCK_MAX;

    // image size arithmetic, one piece per start byte
    assign row_bytes = {1'b0, job_reg.width} + {job_reg.width, 1'b0} + 14'd1;
    assign product   = {14'b0, job_reg.height} * {13'b0, row_bytes};
    assign ceil_x    = {1'b0, raw_reg} + 27'd65534;
    assign q0        = ceil_x[26:16];
    assign rem       = {1'b0, ceil_x[15:0]} + {6'b0, q0};

    // Adler-32 with one conditional subtract per half
    assign lo_sum = {1'b0, alo_reg} + {9'b0, byte_val};
    assign lo_new = (lo_sum >= pse_pkg::ADLER_MOD) ? 16'(lo_sum - pse_pkg::ADLER_MOD)
                                                   : lo_sum[15:0];
    assign hi_sum = {1'b0, ahi_reg} + {1'b0, lo_new};
    assign hi_new = (hi_sum >= pse_pkg::ADLER_MOD) ? 16'(hi_sum - pse_pkg::ADLER_MOD)
                                                   : hi_sum[15:0];

    // select the byte of the current step
    always_comb begin
        byte_val = 8'h00;
        feed     = 1'b0;
        crc_rst  = 1'b0;
        is_last  = 1'b0;
        done_flag = 1'b0;
        err_flag = 1'b0;
        raw_data = 1'b0;
        emit     = 1'b1;
        unique case (state_reg)
            pse_pkg::BK_IDLE: emit = 1'b0;
            pse_pkg::BK_START: begin
                case (step_reg) inside
                    6'd0: byte_val = 8'h89;
                    6'd1: byte_val = 8'h50;
                    6'd2: byte_val = 8'h4e;
                    6'd3: byte_val = 8'h47;
                    6'd4: byte_val = 8'h0d;
                    6'd5: byte_val = 8'h0a;
                    6'd6: byte_val = 8'h1a;
                    6'd7: byte_val = 8'h0a;
                    6'd11: byte_val = 8'd13;
                    6'd12: begin byte_val = 8'h49; crc_rst = 1'b1; end
                    6'd13: byte_val = 8'h48;
                    6'd14: byte_val = 8'h44;
                    6'd15: byte_val = 8'h52;
                    [6'd16:6'd19]: byte_val = be_byte(w_word, step_reg[1:0]);
                    [6'd20:6'd23]: byte_val = be_byte(h_word, step_reg[1:0]);
                    6'd24: byte_val = 8'd8;
                    6'd25: byte_val = 8'd2;
                    [6'd29:6'd32]: byte_val = be_byte(crc_inv, 2'(step_reg - 6'd29));
                    [6'd33:6'd36]: byte_val = be_byte(idat_word, 2'(step_reg - 6'd33));
                    6'd37: begin byte_val = 8'h49; crc_rst = 1'b1; end
                    6'd38: byte_val = 8'h44;
                    6'd39: byte_val = 8'h41;
                    6'd40: byte_val = 8'h54;
                    6'd41: byte_val = 8'h78;
                    6'd42: begin byte_val = 8'h01; is_last = 1'b1; end
                    default: byte_val = 8'h00;
                endcase
                feed = (step_reg >= 6'd12 && step_reg <= 6'd28) || (step_reg >= 6'd37);
            end
            pse_pkg::BK_RAW: begin
                feed = 1'b1;
                if (in_header) begin
                    case (hdr_reg)
                        3'd0: byte_val = {7'b0, raw_left_reg[25:16] == 10'd0};
                        3'd1: byte_val = blk_n[7:0];
                        3'd2: byte_val = blk_n[15:8];
                        3'd3: byte_val = ~blk_n[7:0];
                        default: byte_val = ~blk_n[15:8];
                    endcase
                end else begin
                    raw_data = 1'b1;
                    case (slot_reg)
                        2'd0: byte_val = 8'h00;
                        2'd1: byte_val = job_reg.pixel[23:16];
                        2'd2: byte_val = job_reg.pixel[15:8];
                        default: byte_val = job_reg.pixel[7:0];
                    endcase
                    is_last = (slot_reg == 2'd3) && !job_reg.finish;
                end
            end
            pse_pkg::BK_FIN: begin
                case (step_reg) inside
                    [6'd0:6'd3]: begin
                        byte_val = be_byte(adler_word, step_reg[1:0]);
                        feed = 1'b1;
                    end
                    [6'd4:6'd7]: byte_val = be_byte(crc_inv, step_reg[1:0]);
                    6'd12: begin byte_val = 8'h49; crc_rst = 1'b1; feed = 1'b1; end
                    6'd13: begin byte_val = 8'h45; feed = 1'b1; end
                    6'd14: begin byte_val = 8'h4e; feed = 1'b1; end
                    6'd15: begin byte_val = 8'h44; feed = 1'b1; end
                    [6'd16:6'd19]: byte_val = be_byte(crc_inv, step_reg[1:0]);
                    default: byte_val = 8'h00;
                endcase
                is_last   = (step_reg == 6'd19);
                done_flag = is_last;
            end
            pse_pkg::BK_ERR: begin
                is_last  = 1'b1;
                err_flag = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    assign load   = emit && (!out_valid_reg || m_tready);
    assign pop    = job_valid && ((state_reg == pse_pkg::BK_IDLE) || (load && is_last));
    assign crc_in = crc_rst ? pse_pkg::CRC_ONES : crc_reg;

    // sequence through the bytes of the job
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        hdr_next   = hdr_reg;
        if (load) begin
            unique case (state_reg)
                pse_pkg::BK_START: step_next = step_reg + 6'd1;
                pse_pkg::BK_RAW: begin
                    if (in_header) begin
                        hdr_next = (hdr_reg == 3'd4) ? 3'd0 : hdr_reg + 3'd1;
                    end else if (slot_reg == 2'd3) begin
                        if (job_reg.finish) begin
                            state_next = pse_pkg::BK_FIN;
                            step_next  = 6'd0;
                        end
                    end else begin
                        slot_next = slot_reg + 2'd1;
                    end
                end
                pse_pkg::BK_FIN: step_next = step_reg + 6'd1;
                default: ;
            endcase
            if (is_last) state_next = pse_pkg::BK_IDLE;
        end
        if (pop) begin
            step_next = 6'd0;
            hdr_next  = 3'd0;
            slot_next = job_in.row_start ? 2'd0 : 2'd1;
            unique case (job_in.kind)
                pse_pkg::JOB_START: state_next = pse_pkg::BK_START;
                pse_pkg::JOB_PIXEL: state_next = pse_pkg::BK_RAW;
                default:            state_next = pse_pkg::BK_ERR;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pse_pkg::BK_IDLE;
            step_reg  <= 6'd0;
            slot_reg  <= 2'd0;
            hdr_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            slot_reg  <= slot_next;
            hdr_reg   <= hdr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) job_reg <= job_in;
    end

    // checksums, block counters and size terms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg        <= pse_pkg::CRC_ONES;
            alo_reg        <= 16'd1;
            ahi_reg        <= 16'd0;
            raw_left_reg   <= 26'd0;
            block_left_reg <= 16'd0;
        end else if (load) begin
            if (feed) crc_reg <= pse_pkg::crc_byte(crc_in, byte_val);
            if (state_reg == pse_pkg::BK_START) begin
                if (step_reg == 6'd0) begin
                    alo_reg        <= 16'd1;
                    ahi_reg        <= 16'd0;
                    block_left_reg <= 16'd0;
                end
                if (step_reg == 6'd2) raw_left_reg <= raw_reg;
            end
            if (state_reg == pse_pkg::BK_RAW && in_header && hdr_reg == 3'd4) begin
                block_left_reg <= blk_n;
            end
            if (raw_data) begin
                alo_reg <= lo_new;
                ahi_reg <= hi_new;
                if (block_left_reg != 16'd0) block_left_reg <= block_left_reg - 16'd1;
                if (raw_left_reg != 26'd0) raw_left_reg <= raw_left_reg - 26'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && state_reg == pse_pkg::BK_START) begin
            if (step_reg == 6'd0) raw_reg <= product[25:0];
            if (step_reg == 6'd1) blocks_reg <= q0 + {10'b0, rem >= 17'd65535};
            if (step_reg == 6'd2) begin
                idat_reg <= {1'b0, raw_reg} + {14'b0, blocks_reg, 2'b0}
                            + {16'b0, blocks_reg} + 27'd6;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_byte_reg <= byte_val;
            out_last_reg <= is_last;
            out_done_reg <= done_flag;
            out_err_reg  <= err_flag;
        end
    end

    assign m_tvalid    = out_valid_reg;
    assign data_byte   = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign image_done  = out_done_reg;
    assign error       = out_err_reg;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;
    localparam int DIM_LIMIT = 4096;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       done;
        logic       err;
    } png_byte_t;

    // predicts the PNG byte stream and checks what the encoder emits
    class png_scoreboard;
        png_byte_t   exp_q[$];
        int          mismatches;
        int          bytes_seen;
        int          images_done;
        int          error_items;
        logic [12:0] reg_w, reg_h;
        logic [31:0] crc;
        int unsigned adler_lo, adler_hi;
        int unsigned row, col, blk_left, raw_left, img_w, img_h;
        bit          open;

        function void reset_state();
            exp_q.delete();
            reg_w = 13'd1; reg_h = 13'd1;
            crc = 32'hffffffff;
            adler_lo = 1; adler_hi = 0;
            row = 0; col = 0; blk_left = 0; raw_left = 0;
            open = 0; img_w = 1; img_h = 1;
        endfunction

        function void set_reg(logic idx, logic [12:0] val);
            if (idx == REG_WIDTH) reg_w = val;
            else reg_h = val;
        endfunction

        function int unsigned clamp(logic [12:0] v);
            if (v < 1) return 1;
            if (v > DIM_LIMIT) return DIM_LIMIT;
            return 32'(v);
        endfunction

        function void put(logic [7:0] b, bit with_crc);
            png_byte_t e;
            e.data = b; e.last = 0; e.done = 0; e.err = 0;
            exp_q.insert(exp_q.size(), e);
            if (with_crc) begin
                crc = crc ^ {24'h0, b};
                for (int k = 0; k < 8; k++)
                    crc = crc[0] ? (32'hedb88320 ^ (crc >> 1)) : (crc >> 1);
            end
        endfunction

        function void put32(logic [31:0] v, bit with_crc);
            for (int i = 3; i >= 0; i--) put(v[i*8 +: 8], with_crc);
        endfunction

        // chunk type restarts the CRC
        function void put_type(logic [31:0] t);
            crc = 32'hffffffff;
            put32(t, 1);
        endfunction

        // raw deflate byte, with a stored-block header where a block begins
        function void put_raw(logic [7:0] b);
            int unsigned n;
            logic [15:0] len;
            if (blk_left == 0) begin
                n = raw_left < 65535 ? raw_left : 65535;
                len = 16'(n);
                put((raw_left == n) ? 8'd1 : 8'd0, 1);
                put(len[7:0], 1);
                put(len[15:8], 1);
                put(~len[7:0], 1);
                put(~len[15:8], 1);
                blk_left = n;
            end
            put(b, 1);
            adler_lo = (adler_lo + b) % 65521;
            adler_hi = (adler_hi + adler_lo) % 65521;
            if (blk_left != 0) blk_left--;
            if (raw_left != 0) raw_left--;
        endfunction

        function void note_input(logic cmd, logic [23:0] px);
            int unsigned raw, blocks;
            png_byte_t e;
            if (cmd == CMD_START) begin
                img_w = clamp(reg_w);
                img_h = clamp(reg_h);
                raw = img_h * (1 + 3 * img_w);
                blocks = (raw + 65534) / 65535;
                put32(32'h89504e47, 0);
                put32(32'h0d0a1a0a, 0);
                put32(32'd13, 0);
                put_type("IHDR");
                put32(img_w, 1);
                put32(img_h, 1);
                put(8'd8, 1); put(8'd2, 1); put(8'd0, 1); put(8'd0, 1); put(8'd0, 1);
                put32(crc ^ 32'hffffffff, 0);
                put32(2 + raw + 5 * blocks + 4, 0);
                put_type("IDAT");
                put(8'h78, 1);
                put(8'h01, 1);
                adler_lo = 1; adler_hi = 0;
                row = 0; col = 0; blk_left = 0; raw_left = raw;
                open = 1;
            end else if (!open) begin
                e.data = 0; e.last = 0; e.done = 0; e.err = 1;
                exp_q.insert(exp_q.size(), e);
                error_items++;
            end else begin
                if (col == 0) put_raw(8'd0);
                put_raw(px[23:16]);
                put_raw(px[15:8]);
                put_raw(px[7:0]);
                col++;
                if (col >= img_w) begin
                    col = 0;
                    row++;
                    if (row >= img_h) begin
                        put32({adler_hi[15:0], adler_lo[15:0]}, 1);
                        put32(crc ^ 32'hffffffff, 0);
                        put32(32'd0, 0);
                        put_type("IEND");
                        put32(crc ^ 32'hffffffff, 0);
                        exp_q[exp_q.size()-1].done = 1;
                        open = 0;
                        images_done++;
                    end
                end
            end
            exp_q[exp_q.size()-1].last = 1;
        endfunction

        function void check_byte(logic [7:0] data, logic last, logic done, logic err);
            png_byte_t e;
            bytes_seen++;
            if (exp_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %02h last=%0b done=%0b err=%0b",
                             data, last, done, err);
                return;
            end
            e = exp_q.pop_front();
            if (data !== e.data || last !== e.last || done !== e.done || err !== e.err) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte %0d: expected %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                             bytes_seen, e.data, e.last, e.done, e.err,
                             data, last, done, err);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic        cfg_index = 0;
    logic [12:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = 0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    png_scoreboard sb = new();
    int n_items = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_cnt = 0;

    png_stored_encoder dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always #1 aclk = ~aclk;

    // receiver: switch between four stall patterns, picked at random on a free-running counter
    always @(posedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: begin
                m_tready <= 1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_tready <= (stall_cnt % 8) < 5;
            end
        endcase
    end

    // check every accepted result byte
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
    end

    // send one item; bursts of random length with random gaps between them
    task automatic send(logic cmd, logic [23:0] px);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 1) * $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, px);
        n_items++;
    endtask

    // hold off until every expected byte is out, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.exp_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // write both dimension registers on consecutive edges
    task automatic write_dims(logic [12:0] w, logic [12:0] h);
        cfg_we <= 1;
        cfg_index <= REG_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        sb.set_reg(REG_WIDTH, w);
        cfg_index <= REG_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        sb.set_reg(REG_HEIGHT, h);
        cfg_we <= 0;
    endtask

    task automatic run_image(logic [12:0] w, logic [12:0] h, int cap);
        int np;
        write_dims(w, h);
        send(CMD_START, 24'($urandom));
        np = sb.img_w * sb.img_h;
        if (np > cap) np = cap;
        for (int i = 0; i < np; i++) send(CMD_PIXEL, 24'($urandom));
        drain();
    endtask

    initial begin
        logic [12:0] w, h;
        sb.reset_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // pixels with no image open
        send(CMD_PIXEL, 24'h000000);
        send(CMD_PIXEL, 24'hffffff);
        // default one-pixel image, then a pixel after it closed
        send(CMD_START, 24'h000000);
        send(CMD_PIXEL, 24'hffffff);
        send(CMD_PIXEL, 24'h123456);
        drain();
        // zero dimensions clamp to one
        run_image(13'd0, 13'd0, 1);
        // oversized dimensions clamp to the maximum; abandon by a new start
        write_dims(13'h1fff, 13'h1fff);
        send(CMD_START, 24'h000000);
        send(CMD_PIXEL, 24'h000000);
        send(CMD_PIXEL, 24'hffffff);
        send(CMD_PIXEL, 24'ha5a5a5);
        send(CMD_PIXEL, 24'h5a5a5a);
        drain();
        write_dims(13'd3, 13'd2);
        send(CMD_START, 24'hffffff);
        for (int i = 0; i < 6; i++) send(CMD_PIXEL, {8'(i * 40), 8'(255 - i), 8'(i)});
        drain();

        // random images, mostly complete, some abandoned, some noise
        while (n_items < 370) begin
            case ($urandom_range(0, 9))
                0: w = 13'd0;
                1: w = 13'h1fff;
                2: w = 13'd4096;
                default: w = 13'($urandom_range(1, 6));
            endcase
            h = ($urandom_range(0, 9) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
            if ($urandom_range(0, 5) == 0) begin
                send(CMD_PIXEL, 24'($urandom));
                drain();
            end
            run_image(w, h, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 40);
        end

        $display("covered %0d items, %0d bytes, %0d finished images, %0d error items",
                 n_items, sb.bytes_seen, sb.images_done, sb.error_items);
        $display("clamped sizes, abandoned images and stray pixels ran under output stalls");
        if (sb.mismatches == 0 && sb.exp_q.size() == 0) begin
            $display("PASS png_stored_encoder");
        end else begin
            $display("%0d mismatches, %0d bytes missing", sb.mismatches, sb.exp_q.size());
            $display("FAIL png_stored_encoder");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout with %0d bytes outstanding", sb.exp_q.size());
        $display("FAIL png_stored_encoder");
        $finish;
    end

endmodule

// ----- png_stored_encoder.f -----
design/pse_pkg.sv
design/pse_front.sv
design/pse_fifo.sv
design/pse_back.sv
design/png_stored_encoder.sv
tb/tb_top.sv
